// File: sv/assert_macros.svh
// Assertion macros shared by the spline evaluator RTL.
// Each macro expands to one labeled concurrent assertion on the rising clock edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CRD_ASSERT_NOW(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define CRD_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: sv/crd_pkg.sv
// Types, widths and term tables for the non-uniform Catmull-Rom evaluator.
// Used by every module of the block; depends on nothing.
package crd_pkg;

    localparam int DATA_W    = 32;
    localparam int DIF_W     = DATA_W + 1;
    localparam int PROD2_W   = 2 * DIF_W;
    localparam int PART_W    = PROD2_W + 1;
    localparam int SUM_W     = PROD2_W + 2;
    localparam int PROD3_W   = 3 * DIF_W;
    localparam int ROUND_SH  = 16;
    localparam int NUM_W     = PROD3_W + ROUND_SH;
    localparam int DEN_W     = PROD3_W;
    localparam int QUOT_BITS = 61;
    localparam int TERM_W    = QUOT_BITS + 1;
    localparam int DIV_LAT   = QUOT_BITS + 4;
    localparam int NUM_TERMS = 8;
    localparam int NUM_DEN   = 4;
    localparam int NUM_TRIP  = NUM_TERMS + NUM_DEN;
    localparam int NUM_PTS   = 4;
    localparam int NUM_FAC   = 6;
    localparam int WSUM_W    = 64;
    localparam int ACC_W     = 66;

    // Largest magnitude a single term quotient may take.
    localparam logic [TERM_W-1:0] TERM_LIM = {2'b01, {(QUOT_BITS - 1){1'b0}}};

    typedef struct packed {
        logic signed [DATA_W-1:0] knot_0;
        logic signed [DATA_W-1:0] knot_1;
        logic signed [DATA_W-1:0] knot_2;
        logic signed [DATA_W-1:0] knot_3;
        logic signed [DATA_W-1:0] param_x;
        logic signed [DATA_W-1:0] point_a;
        logic signed [DATA_W-1:0] point_b;
        logic signed [DATA_W-1:0] point_c;
        logic signed [DATA_W-1:0] point_d;
    } crd_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] curve_value;
        logic signed [DATA_W-1:0] curve_slope;
        logic signed [DATA_W-1:0] weight_a;
        logic signed [DATA_W-1:0] weight_b;
        logic signed [DATA_W-1:0] weight_c;
        logic signed [DATA_W-1:0] weight_d;
        logic signed [DATA_W-1:0] slope_weight_a;
        logic signed [DATA_W-1:0] slope_weight_b;
        logic signed [DATA_W-1:0] slope_weight_c;
        logic signed [DATA_W-1:0] slope_weight_d;
        logic                     knot_error;
    } crd_result_t;

    typedef logic [NUM_PTS-1:0][DATA_W-1:0] crd_pts_t;
    typedef logic [NUM_TERMS-1:0][TERM_W-1:0] crd_terms_t;

    // Differences that act as cubic factors.
    typedef enum logic [2:0] {
        FAC_T2MX,
        FAC_T1MX,
        FAC_T3MX,
        FAC_XMT0,
        FAC_XMT1,
        FAC_XMT2
    } crd_fac_e;

    typedef struct packed {
        logic [NUM_FAC-1:0][DIF_W-1:0] fac;
        logic signed [DIF_W-1:0]       d10;
        logic signed [DIF_W-1:0]       d21;
        logic signed [DIF_W-1:0]       d32;
        logic signed [DIF_W-1:0]       d20;
        logic signed [DIF_W-1:0]       d31;
        crd_pts_t                      pts;
        logic                          err;
    } crd_diff_t;

    typedef struct packed {
        logic [NUM_TERMS-1:0][NUM_W-1:0] nval;
        logic [NUM_TERMS-1:0][NUM_W-1:0] nder;
        logic [NUM_DEN-1:0][DEN_W-1:0]   den;
        crd_pts_t                        pts;
        logic                            err;
    } crd_num_t;

    // Factors of every cubic term.
    localparam crd_fac_e TERM_F1 [NUM_TERMS] = '{
        FAC_T2MX, FAC_T2MX, FAC_T2MX, FAC_XMT1, FAC_T2MX, FAC_XMT1, FAC_XMT1, FAC_XMT1};
    localparam crd_fac_e TERM_F2 [NUM_TERMS] = '{
        FAC_T2MX, FAC_T2MX, FAC_T2MX, FAC_T3MX, FAC_XMT0, FAC_XMT1, FAC_XMT1, FAC_XMT1};
    localparam crd_fac_e TERM_F3 [NUM_TERMS] = '{
        FAC_T1MX, FAC_XMT0, FAC_XMT0, FAC_T2MX, FAC_XMT1, FAC_T3MX, FAC_T3MX, FAC_XMT2};

    // Bit 2, 1, 0 mark the first, second, third factor as falling with x.
    localparam logic [2:0] TERM_NEG [NUM_TERMS] = '{
        3'b111, 3'b110, 3'b110, 3'b011, 3'b100, 3'b001, 3'b001, 3'b000};

    // Denominator used by each term, and the weight it adds into.
    localparam logic [1:0] TERM_DEN [NUM_TERMS] = '{
        2'd0, 2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd3, 2'd3};
    localparam logic [1:0] TERM_WGT [NUM_TERMS] = '{
        2'd0, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd3};

endpackage

// File: sv/crd_front.sv
// Input stage: knot and parameter differences plus the knot order check.
// Depends on crd_pkg.
module crd_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                vld,
    input  crd_pkg::crd_item_t  item,
    output logic                diff_vld,
    output crd_pkg::crd_diff_t  diff
);
    import crd_pkg::*;

    logic      vld_reg;
    crd_diff_t diff_reg;
    crd_diff_t diff_next;

    function automatic logic signed [DIF_W-1:0] sub_ext(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        return DIF_W'(a) - DIF_W'(b);
    endfunction

    // Exact 33-bit differences and the strict ordering test.
    always_comb
    begin
        diff_next               = '0;
        diff_next.fac[FAC_T2MX] = sub_ext(item.knot_2, item.param_x);
        diff_next.fac[FAC_T1MX] = sub_ext(item.knot_1, item.param_x);
        diff_next.fac[FAC_T3MX] = sub_ext(item.knot_3, item.param_x);
        diff_next.fac[FAC_XMT0] = sub_ext(item.param_x, item.knot_0);
        diff_next.fac[FAC_XMT1] = sub_ext(item.param_x, item.knot_1);
        diff_next.fac[FAC_XMT2] = sub_ext(item.param_x, item.knot_2);
        diff_next.d10           = sub_ext(item.knot_1, item.knot_0);
        diff_next.d21           = sub_ext(item.knot_2, item.knot_1);
        diff_next.d32           = sub_ext(item.knot_3, item.knot_2);
        diff_next.d20           = sub_ext(item.knot_2, item.knot_0);
        diff_next.d31           = sub_ext(item.knot_3, item.knot_1);
        diff_next.pts           = {item.point_d, item.point_c, item.point_b, item.point_a};
        diff_next.err           = !((item.knot_0 < item.knot_1) && (item.knot_1 < item.knot_2)
                                    && (item.knot_2 < item.knot_3));
    end

    // Valid bit of the stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= vld;
        end
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            diff_reg <= diff_next;
        end
    end

    assign diff_vld = vld_reg;
    assign diff     = diff_reg;

endmodule

// File: sv/crd_numer.sv
// Three-stage product pipeline: term numerators, slope numerators, denominators.
// Depends on crd_pkg.
module crd_numer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               diff_vld,
    input  crd_pkg::crd_diff_t diff,
    output logic               num_vld,
    output crd_pkg::crd_num_t  num
);
    import crd_pkg::*;

    // First stage: 33x33 pair products and the third factor.
    logic signed [PROD2_W-1:0] pair_reg  [NUM_TRIP];
    logic signed [PROD2_W-1:0] pair_next [NUM_TRIP];
    logic signed [DIF_W-1:0]   third_reg [NUM_TRIP];
    logic signed [DIF_W-1:0]   third_next[NUM_TRIP];
    logic signed [PROD2_W-1:0] p13_reg   [NUM_TERMS];
    logic signed [PROD2_W-1:0] p13_next  [NUM_TERMS];
    logic signed [PROD2_W-1:0] p23_reg   [NUM_TERMS];
    logic signed [PROD2_W-1:0] p23_next  [NUM_TERMS];
    crd_pts_t                  pts2_reg;
    logic                      err2_reg;
    logic                      vld2_reg;

    // Second stage: split partial products and the slope sums.
    logic signed [PART_W-1:0]  plo_reg   [NUM_TRIP];
    logic signed [PART_W-1:0]  plo_next  [NUM_TRIP];
    logic signed [PROD2_W-1:0] phi_reg   [NUM_TRIP];
    logic signed [PROD2_W-1:0] phi_next  [NUM_TRIP];
    logic signed [SUM_W-1:0]   s_reg     [NUM_TERMS];
    logic signed [SUM_W-1:0]   s_next    [NUM_TERMS];
    crd_pts_t                  pts3_reg;
    logic                      err3_reg;
    logic                      vld3_reg;

    // Third stage: full cubic products and scaled numerators.
    logic [PROD3_W-1:0]        p3        [NUM_TRIP];
    crd_num_t                  num_reg;
    crd_num_t                  num_next;
    logic                      vld4_reg;

    always_comb
    begin
        for (int t = 0; t < NUM_TERMS; t++)
        begin
            pair_next[t]  = $signed(diff.fac[TERM_F1[t]]) * $signed(diff.fac[TERM_F2[t]]);
            p13_next[t]   = $signed(diff.fac[TERM_F1[t]]) * $signed(diff.fac[TERM_F3[t]]);
            p23_next[t]   = $signed(diff.fac[TERM_F2[t]]) * $signed(diff.fac[TERM_F3[t]]);
            third_next[t] = $signed(diff.fac[TERM_F3[t]]);
        end
        pair_next[NUM_TERMS]      = diff.d21 * diff.d20;
        third_next[NUM_TERMS]     = diff.d10;
        pair_next[NUM_TERMS + 1]  = diff.d21 * diff.d21;
        third_next[NUM_TERMS + 1] = diff.d20;
        pair_next[NUM_TERMS + 2]  = diff.d21 * diff.d21;
        third_next[NUM_TERMS + 2] = diff.d31;
        pair_next[NUM_TERMS + 3]  = diff.d21 * diff.d31;
        third_next[NUM_TERMS + 3] = diff.d32;
    end

    // The 66x33 product is cut into a low and a high 33-bit half.
    always_comb
    begin
        for (int i = 0; i < NUM_TRIP; i++)
        begin
            plo_next[i] = $signed({1'b0, pair_reg[i][DIF_W-1:0]}) * third_reg[i];
            phi_next[i] = $signed(pair_reg[i][PROD2_W-1:DIF_W]) * third_reg[i];
        end
        // Product rule: a factor that falls with x flips the sign of its partner pair.
        for (int t = 0; t < NUM_TERMS; t++)
        begin
            s_next[t] = (TERM_NEG[t][2] ? -SUM_W'(p23_reg[t]) : SUM_W'(p23_reg[t]))
                      + (TERM_NEG[t][1] ? -SUM_W'(p13_reg[t]) : SUM_W'(p13_reg[t]))
                      + (TERM_NEG[t][0] ? -SUM_W'(pair_reg[t]) : SUM_W'(pair_reg[t]));
        end
    end

    // Recombine halves and scale the numerators to the quotient's binary point.
    always_comb
    begin
        num_next     = '0;
        num_next.pts = pts3_reg;
        num_next.err = err3_reg;
        for (int i = 0; i < NUM_TRIP; i++)
        begin
            p3[i] = {phi_reg[i], {DIF_W{1'b0}}}
                  + {{(PROD3_W - PART_W){plo_reg[i][PART_W-1]}}, plo_reg[i]};
        end
        for (int t = 0; t < NUM_TERMS; t++)
        begin
            num_next.nval[t] = {p3[t], {ROUND_SH{1'b0}}};
            num_next.nder[t] = {{(NUM_W - SUM_W - DATA_W){s_reg[t][SUM_W-1]}}, s_reg[t],
                                {DATA_W{1'b0}}};
        end
        for (int k = 0; k < NUM_DEN; k++)
        begin
            num_next.den[k] = p3[NUM_TERMS + k];
        end
    end

    // Valid bits of the three stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
        end
        else if (en)
        begin
            vld2_reg <= diff_vld;
            vld3_reg <= vld2_reg;
            vld4_reg <= vld3_reg;
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pair_reg  <= pair_next;
            third_reg <= third_next;
            p13_reg   <= p13_next;
            p23_reg   <= p23_next;
            pts2_reg  <= diff.pts;
            err2_reg  <= diff.err;
            plo_reg   <= plo_next;
            phi_reg   <= phi_next;
            s_reg     <= s_next;
            pts3_reg  <= pts2_reg;
            err3_reg  <= err2_reg;
            num_reg   <= num_next;
        end
    end

    assign num_vld = vld4_reg;
    assign num     = num_reg;

endmodule

// File: sv/crd_div.sv
// Pipelined restoring divider, one quotient bit per stage, rounded and clamped.
// Depends on crd_pkg.
module crd_div (
    input  logic                            clk,
    input  logic                            en,
    input  logic signed [crd_pkg::NUM_W-1:0] num,
    input  logic        [crd_pkg::DEN_W-1:0] den,
    output logic signed [crd_pkg::TERM_W-1:0] term
);
    import crd_pkg::*;

    // Sign and magnitude stage.
    logic                   sg0_reg;
    logic                   sg0_next;
    logic [NUM_W-1:0]       mag0_reg;
    logic [NUM_W-1:0]       mag0_next;
    logic [DEN_W-1:0]       d0_reg;

    // Quotient bit stages; index 0 holds the overflow check.
    logic [DEN_W-1:0]       r_reg    [QUOT_BITS+1];
    logic [DEN_W-1:0]       r_next   [QUOT_BITS+1];
    logic [QUOT_BITS-1:0]   lo_reg   [QUOT_BITS+1];
    logic [QUOT_BITS-1:0]   lo_next  [QUOT_BITS+1];
    logic [QUOT_BITS-1:0]   q_reg    [QUOT_BITS+1];
    logic [QUOT_BITS-1:0]   q_next   [QUOT_BITS+1];
    logic [DEN_W-1:0]       d_reg    [QUOT_BITS+1];
    logic [DEN_W-1:0]       d_next   [QUOT_BITS+1];
    logic                   sg_reg   [QUOT_BITS+1];
    logic                   sg_next  [QUOT_BITS+1];
    logic                   ovf_reg  [QUOT_BITS+1];
    logic                   ovf_next [QUOT_BITS+1];
    logic [DEN_W:0]         trial    [QUOT_BITS];
    logic [DEN_W:0]         rest     [QUOT_BITS];
    logic                   fits     [QUOT_BITS];

    // Rounding and final stages.
    logic                   up;
    logic [TERM_W-1:0]      q1_reg;
    logic [TERM_W-1:0]      q1_next;
    logic                   sg1_reg;
    logic                   ovf1_reg;
    logic [TERM_W-1:0]      mag_sat;
    logic [TERM_W-1:0]      term_reg;
    logic [TERM_W-1:0]      term_next;

    assign sg0_next  = num[NUM_W-1];
    assign mag0_next = num[NUM_W-1] ? (~num + 1'b1) : num;

    // Overflow test on the high part and the quotient bit steps.
    always_comb
    begin
        r_next[0]   = DEN_W'(mag0_reg[NUM_W-1:QUOT_BITS]);
        ovf_next[0] = DEN_W'(mag0_reg[NUM_W-1:QUOT_BITS]) >= d0_reg;
        lo_next[0]  = mag0_reg[QUOT_BITS-1:0];
        q_next[0]   = '0;
        d_next[0]   = d0_reg;
        sg_next[0]  = sg0_reg;
        for (int j = 1; j <= QUOT_BITS; j++)
        begin
            trial[j-1]  = {r_reg[j-1], lo_reg[j-1][QUOT_BITS-1]};
            rest[j-1]   = trial[j-1] - {1'b0, d_reg[j-1]};
            fits[j-1]   = trial[j-1] >= {1'b0, d_reg[j-1]};
            r_next[j]   = fits[j-1] ? rest[j-1][DEN_W-1:0] : trial[j-1][DEN_W-1:0];
            lo_next[j]  = {lo_reg[j-1][QUOT_BITS-2:0], 1'b0};
            q_next[j]   = {q_reg[j-1][QUOT_BITS-2:0], fits[j-1]};
            d_next[j]   = d_reg[j-1];
            sg_next[j]  = sg_reg[j-1];
            ovf_next[j] = ovf_reg[j-1];
        end
    end

    // Round to nearest, ties away from zero, then clamp and restore the sign.
    assign up        = {r_reg[QUOT_BITS], 1'b0} >= {1'b0, d_reg[QUOT_BITS]};
    assign q1_next   = {1'b0, q_reg[QUOT_BITS]} + TERM_W'(up);
    assign mag_sat   = (ovf1_reg || (q1_reg > TERM_LIM)) ? TERM_LIM : q1_reg;
    assign term_next = sg1_reg ? (~mag_sat + 1'b1) : mag_sat;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sg0_reg  <= sg0_next;
            mag0_reg <= mag0_next;
            d0_reg   <= den;
            r_reg    <= r_next;
            lo_reg   <= lo_next;
            q_reg    <= q_next;
            d_reg    <= d_next;
            sg_reg   <= sg_next;
            ovf_reg  <= ovf_next;
            q1_reg   <= q1_next;
            sg1_reg  <= sg_reg[QUOT_BITS];
            ovf1_reg <= ovf_reg[QUOT_BITS];
            term_reg <= term_next;
        end
    end

    assign term = term_reg;

endmodule

// File: sv/crd_back.sv
// Back end: weight sums, dot products with the control values, output register.
// Depends on crd_pkg.
module crd_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 vld,
    input  logic                 err,
    input  crd_pkg::crd_pts_t    pts,
    input  crd_pkg::crd_terms_t  val,
    input  crd_pkg::crd_terms_t  der,
    output logic                 res_vld,
    output crd_pkg::crd_result_t res
);
    import crd_pkg::*;

    logic signed [WSUM_W-1:0]   wv       [NUM_PTS];
    logic signed [WSUM_W-1:0]   dv       [NUM_PTS];
    logic signed [DATA_W-1:0]   w_next   [NUM_PTS];
    logic signed [DATA_W-1:0]   dw_next  [NUM_PTS];
    logic signed [DATA_W-1:0]   w_reg    [NUM_PTS];
    logic signed [DATA_W-1:0]   dw_reg   [NUM_PTS];
    logic signed [DATA_W-1:0]   w_m_reg  [NUM_PTS];
    logic signed [DATA_W-1:0]   dw_m_reg [NUM_PTS];
    logic signed [DATA_W-1:0]   w_a_reg  [NUM_PTS];
    logic signed [DATA_W-1:0]   dw_a_reg [NUM_PTS];
    logic signed [2*DATA_W-1:0] pv_next  [NUM_PTS];
    logic signed [2*DATA_W-1:0] pd_next  [NUM_PTS];
    logic signed [2*DATA_W-1:0] pv_reg   [NUM_PTS];
    logic signed [2*DATA_W-1:0] pd_reg   [NUM_PTS];
    logic        [ACC_W-1:0]    accv_next;
    logic        [ACC_W-1:0]    accd_next;
    logic        [ACC_W-1:0]    accv_reg;
    logic        [ACC_W-1:0]    accd_reg;
    crd_pts_t                   pts_w_reg;
    logic                       err_w_reg;
    logic                       err_m_reg;
    logic                       err_a_reg;
    logic                       vld_w_reg;
    logic                       vld_m_reg;
    logic                       vld_a_reg;
    logic                       vld_o_reg;
    crd_result_t                res_reg;
    crd_result_t                res_next;

    function automatic logic [DATA_W-1:0] sat32(input logic [ACC_W-1:0] v);
        if (!v[ACC_W-1] && (|v[ACC_W-2:DATA_W-1]))
        begin
            return {1'b0, {(DATA_W - 1){1'b1}}};
        end
        if (v[ACC_W-1] && !(&v[ACC_W-2:DATA_W-1]))
        begin
            return {1'b1, {(DATA_W - 1){1'b0}}};
        end
        return v[DATA_W-1:0];
    endfunction

    // Divide by 2^16, rounding to nearest with ties away from zero, then saturate.
    function automatic logic [DATA_W-1:0] round_q16(input logic [ACC_W-1:0] acc);
        logic [ACC_W-1:0] mag;
        logic [ACC_W-1:0] mq;
        mag = acc[ACC_W-1] ? (~acc + 1'b1) : acc;
        mq  = (mag + (ACC_W'(1) << (ROUND_SH - 1))) >> ROUND_SH;
        return sat32(acc[ACC_W-1] ? (~mq + 1'b1) : mq);
    endfunction

    // Each weight gathers its terms and saturates to 32 bits.
    always_comb
    begin
        for (int i = 0; i < NUM_PTS; i++)
        begin
            wv[i] = '0;
            dv[i] = '0;
        end
        for (int t = 0; t < NUM_TERMS; t++)
        begin
            wv[TERM_WGT[t]] = wv[TERM_WGT[t]] + WSUM_W'($signed(val[t]));
            dv[TERM_WGT[t]] = dv[TERM_WGT[t]] + WSUM_W'($signed(der[t]));
        end
        for (int i = 0; i < NUM_PTS; i++)
        begin
            w_next[i]  = sat32(ACC_W'(wv[i]));
            dw_next[i] = sat32(ACC_W'(dv[i]));
        end
    end

    // Products of weights and control values, then their exact sums.
    always_comb
    begin
        accv_next = '0;
        accd_next = '0;
        for (int i = 0; i < NUM_PTS; i++)
        begin
            pv_next[i] = w_reg[i] * $signed(pts_w_reg[i]);
            pd_next[i] = dw_reg[i] * $signed(pts_w_reg[i]);
            accv_next  = accv_next + ACC_W'(pv_reg[i]);
            accd_next  = accd_next + ACC_W'(pd_reg[i]);
        end
    end

    // Output beat; a knot error clears every numeric field.
    always_comb
    begin
        res_next = '0;
        if (err_a_reg)
        begin
            res_next.knot_error = 1'b1;
        end
        else
        begin
            res_next.curve_value    = round_q16(accv_reg);
            res_next.curve_slope    = round_q16(accd_reg);
            res_next.weight_a       = w_a_reg[0];
            res_next.weight_b       = w_a_reg[1];
            res_next.weight_c       = w_a_reg[2];
            res_next.weight_d       = w_a_reg[3];
            res_next.slope_weight_a = dw_a_reg[0];
            res_next.slope_weight_b = dw_a_reg[1];
            res_next.slope_weight_c = dw_a_reg[2];
            res_next.slope_weight_d = dw_a_reg[3];
        end
    end

    // Valid bits of the four stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_w_reg <= 1'b0;
            vld_m_reg <= 1'b0;
            vld_a_reg <= 1'b0;
            vld_o_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_w_reg <= vld;
            vld_m_reg <= vld_w_reg;
            vld_a_reg <= vld_m_reg;
            vld_o_reg <= vld_a_reg;
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w_reg     <= w_next;
            dw_reg    <= dw_next;
            pts_w_reg <= pts;
            err_w_reg <= err;
            pv_reg    <= pv_next;
            pd_reg    <= pd_next;
            w_m_reg   <= w_reg;
            dw_m_reg  <= dw_reg;
            err_m_reg <= err_w_reg;
            accv_reg  <= accv_next;
            accd_reg  <= accd_next;
            w_a_reg   <= w_m_reg;
            dw_a_reg  <= dw_m_reg;
            err_a_reg <= err_m_reg;
            res_reg   <= res_next;
        end
    end

    assign res_vld = vld_o_reg;
    assign res     = res_reg;

endmodule

// File: sv/catmull_rom_eval_with_derivative.sv
// Non-uniform Catmull-Rom segment evaluator with derivative, all values signed Q16.16.
// It takes one beat per clock unless the output is stalled and returns one result beat
// per input beat, in order, through one difference stage, three product stages, the
// 65-stage dividers (sixteen of them, one quotient bit per stage plus sign, overflow,
// rounding and clamp stages) and four stages of weight sums, dot products and output
// rounding. When the result beat is stalled the whole pipeline holds, and item_stall
// rises in that same cycle; bubbles are not squeezed out. Uses crd_pkg, crd_front,
// crd_numer, crd_div, crd_back and assert_macros.svh.
`include "assert_macros.svh"

module catmull_rom_eval_with_derivative (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  crd_pkg::crd_item_t   item,
    output logic                 result_valid,
    input  logic                 result_stall,
    output crd_pkg::crd_result_t result
);
    import crd_pkg::*;

    logic         en;
    logic         fr_vld;
    crd_diff_t    fr_diff;
    logic         num_vld;
    crd_num_t     num;
    crd_terms_t   tval;
    crd_terms_t   tder;
    logic         res_clear;

    // Side line that carries valid, error and control values past the dividers.
    logic [DIV_LAT-1:0] div_vld_reg;
    logic [DIV_LAT-1:0] div_vld_next;
    logic [DIV_LAT-1:0] side_err_reg;
    logic [DIV_LAT-1:0] side_err_next;
    crd_pts_t           side_pts_reg  [DIV_LAT];
    crd_pts_t           side_pts_next [DIV_LAT];

    // The pipeline moves unless a finished beat is held at the output.
    assign en         = !(result_valid && result_stall);
    assign item_stall = !en;

    crd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vld      (item_valid),
        .item     (item),
        .diff_vld (fr_vld),
        .diff     (fr_diff)
    );

    crd_numer u_numer (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .diff_vld (fr_vld),
        .diff     (fr_diff),
        .num_vld  (num_vld),
        .num      (num)
    );

    // One divider for each term value and each term slope.
    for (genvar t = 0; t < NUM_TERMS; t++)
    begin : g_term
        crd_div u_div_val (
            .clk  (clk),
            .en   (en),
            .num  ($signed(num.nval[t])),
            .den  (num.den[TERM_DEN[t]]),
            .term (tval[t])
        );
        crd_div u_div_der (
            .clk  (clk),
            .en   (en),
            .num  ($signed(num.nder[t])),
            .den  (num.den[TERM_DEN[t]]),
            .term (tder[t])
        );
    end

    always_comb
    begin
        div_vld_next     = {div_vld_reg[DIV_LAT-2:0], num_vld};
        side_err_next    = {side_err_reg[DIV_LAT-2:0], num.err};
        side_pts_next[0] = num.pts;
        for (int k = 1; k < DIV_LAT; k++)
        begin
            side_pts_next[k] = side_pts_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_vld_reg <= '0;
        end
        else if (en)
        begin
            div_vld_reg <= div_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_err_reg <= side_err_next;
            side_pts_reg <= side_pts_next;
        end
    end

    crd_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .vld     (div_vld_reg[DIV_LAT-1]),
        .err     (side_err_reg[DIV_LAT-1]),
        .pts     (side_pts_reg[DIV_LAT-1]),
        .val     (tval),
        .der     (tder),
        .res_vld (result_valid),
        .res     (result)
    );

    // Four numeric fields of the output beat that must be zero on a knot error.
    assign res_clear = (result.curve_value == '0) && (result.curve_slope == '0)
                     && (result.weight_a == '0) && (result.slope_weight_d == '0);

    // A knot error result carries zero in the four checked numeric fields.
    `CRD_ASSERT_NOW(a_err_zero, clk, rst_n, result_valid && result.knot_error, res_clear)
    // An accepted beat is in the first stage in the next cycle.
    `CRD_ASSERT_NEXT(a_accept_enters, clk, rst_n, item_valid && !item_stall, fr_vld)
    // A held output freezes the divider side line.
    `CRD_ASSERT_NEXT(a_freeze, clk, rst_n, !en, $stable(div_vld_reg))

endmodule
